// ----- rtl/core/gssc_pkg.sv -----
package gssc_pkg;

    localparam int GENERATION_BITS = 32;
    localparam int RATE_BITS       = 20;

    // Slot index codes.
    localparam logic [1:0] SLOT_0    = 2'd0;
    localparam logic [1:0] SLOT_NONE = 2'd3;

    // Operation codes.
    localparam logic [2:0] OP_PREP_INIT    = 3'd0;
    localparam logic [2:0] OP_PREP_PENDING = 3'd1;
    localparam logic [2:0] OP_RETRACT      = 3'd2;
    localparam logic [2:0] OP_CONSUME      = 3'd3;
    localparam logic [2:0] OP_RELEASE_PREV = 3'd4;
    localparam logic [2:0] OP_QUERY        = 3'd5;

    typedef struct packed {
        logic [2:0]                 op;
        logic [GENERATION_BITS-1:0] new_generation;
        logic [RATE_BITS-1:0]       new_sample_rate;
        logic                       prepare_ok;
    } gssc_cmd_t;

    typedef struct packed {
        logic       accepted;
        logic [1:0] active_slot;
        logic [1:0] pending_slot;
        logic [1:0] previous_slot;
        logic       swapped;
        logic       rate_changed;
    } gssc_res_t;

endpackage

// ----- rtl/core/gssc_slot_ctrl.sv -----
module gssc_slot_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  gssc_pkg::gssc_cmd_t cmd,
    output gssc_pkg::gssc_res_t result
);
    import gssc_pkg::*;

    logic [1:0] active_reg, active_next;
    logic [1:0] pending_reg, pending_next;
    logic [1:0] previous_reg, previous_next;

    // Per-slot store, meaningful only once the slot has been prepared.
    logic [GENERATION_BITS-1:0] gen_reg [2];
    logic [RATE_BITS-1:0]       rate_reg [2];

    logic       wr_en;
    logic       wr_slot;
    logic       accepted;
    logic       swapped;
    logic       rate_changed;
    logic       all_none;
    logic       gen_newer;

    assign all_none  = (active_reg == SLOT_NONE) && (pending_reg == SLOT_NONE)
                       && (previous_reg == SLOT_NONE);
    assign gen_newer = cmd.new_generation > gen_reg[active_reg[0]];

    always_comb
    begin
        active_next   = active_reg;
        pending_next  = pending_reg;
        previous_next = previous_reg;
        wr_en         = 1'b0;
        wr_slot       = 1'b0;
        accepted      = 1'b0;
        swapped       = 1'b0;
        rate_changed  = 1'b0;
        case (cmd.op)
            OP_PREP_INIT:
            begin
                if (all_none && cmd.prepare_ok)
                begin
                    wr_en       = 1'b1;
                    wr_slot     = 1'b0;
                    active_next = SLOT_0;
                    accepted    = 1'b1;
                end
            end
            OP_PREP_PENDING:
            begin
                if ((active_reg != SLOT_NONE) && (pending_reg == SLOT_NONE) &&
                    (previous_reg == SLOT_NONE) && gen_newer && cmd.prepare_ok)
                begin
                    wr_en        = 1'b1;
                    wr_slot      = ~active_reg[0];
                    pending_next = {1'b0, ~active_reg[0]};
                    accepted     = 1'b1;
                end
            end
            OP_RETRACT:
            begin
                pending_next = SLOT_NONE;
            end
            OP_CONSUME:
            begin
                if (pending_reg != SLOT_NONE)
                begin
                    // A pending slot always sits opposite the active one, so the
                    // rate check compares the two slots directly.
                    rate_changed  = (active_reg != SLOT_NONE) &&
                                    (rate_reg[0] != rate_reg[1]);
                    active_next   = pending_reg;
                    pending_next  = SLOT_NONE;
                    previous_next = active_reg;
                    swapped       = 1'b1;
                end
            end
            OP_RELEASE_PREV:
            begin
                previous_next = SLOT_NONE;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= SLOT_NONE;
            pending_reg  <= SLOT_NONE;
            previous_reg <= SLOT_NONE;
        end
        else if (step)
        begin
            active_reg   <= active_next;
            pending_reg  <= pending_next;
            previous_reg <= previous_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && wr_en)
        begin
            gen_reg[wr_slot]  <= cmd.new_generation;
            rate_reg[wr_slot] <= cmd.new_sample_rate;
        end
    end

    assign result.accepted      = accepted;
    assign result.active_slot   = active_next;
    assign result.pending_slot  = pending_next;
    assign result.previous_slot = previous_next;
    assign result.swapped       = swapped;
    assign result.rate_changed  = rate_changed;

endmodule

// ----- rtl/core/graph_slot_swap_control.sv -----
// Slot controller for two processing-graph slots run as a double buffer with
// a retire slot. Each command word carries one operation (prepare initial,
// prepare pending, retract, consume, release previous, query) and yields
// exactly one result word with the slot indices after the operation and the
// accepted, swapped and rate-changed flags. The block takes one command word
// per clock cycle while the result side does not stall; a command is held in
// the command register on acceptance, evaluated against the slot state once
// the result register is free or being emptied, and its result word is held
// in the result register, which sits between the two sides, so a new command
// is taken while a finished result still waits if the command register is
// empty, and the combined path through the slot-state update sets that rate.
// When the result side stalls, at most one further command is held in the
// command register. Slot indices 0 and 1 name a slot; 3 means none.
module graph_slot_swap_control (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  gssc_pkg::gssc_cmd_t cmd,
    output logic                res_valid,
    input  logic                res_ready,
    output gssc_pkg::gssc_res_t res
);
    import gssc_pkg::*;

    gssc_cmd_t cmd_reg;
    logic      cmd_valid_reg, cmd_valid_next;
    gssc_res_t res_reg;
    logic      res_valid_reg, res_valid_next;
    gssc_res_t result;
    logic      step;

    // The registered command is evaluated whenever the result register is free
    // or is being emptied in this same cycle.
    assign step      = cmd_valid_reg && (!res_valid_reg || res_ready);
    assign cmd_ready = !cmd_valid_reg || step;

    assign cmd_valid_next = cmd_ready ? cmd_valid : cmd_valid_reg;
    assign res_valid_next = step ? 1'b1 : (res_ready ? 1'b0 : res_valid_reg);

    gssc_slot_ctrl u_slot_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .cmd    (cmd_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            cmd_reg <= cmd;
        end
        if (step)
        begin
            res_reg <= result;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ----- rtl/core/gssc_checker.sv -----
module gssc_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                cmd_valid,
    input logic                cmd_ready,
    input gssc_pkg::gssc_cmd_t cmd,
    input logic                res_valid,
    input logic                res_ready,
    input gssc_pkg::gssc_res_t res
);
    import gssc_pkg::*;

    // A rate change is only ever reported as part of a swap.
    a_rate_needs_swap: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.rate_changed |-> res.swapped)
        else $error("rate_changed without swapped");

    // A swap leaves nothing pending and a slot active, and is not flagged accepted.
    a_swap_shape: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.swapped |->
            (res.pending_slot == SLOT_NONE) && (res.active_slot != SLOT_NONE)
            && !res.accepted)
        else $error("inconsistent slots after swap");

    // A pending slot always has an active slot opposite to it.
    a_pending_opposite: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res.pending_slot != SLOT_NONE) |->
            (res.active_slot != SLOT_NONE) &&
            (res.pending_slot[0] != res.active_slot[0]))
        else $error("pending slot not opposite active slot");

    // A stalled result word holds.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result word changed while stalled");

    // A command word that is not taken stays presented and unchanged.
    a_cmd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd))
        else $error("command word changed while waiting");

endmodule

bind graph_slot_swap_control gssc_checker u_gssc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
);
